// ===== src/dsm_pkg.sv =====
// Shared types, constants and the quarter-wave sine table of the DPSK symbol modulator.
package dsm_pkg;

    // Field and register widths
    localparam int SYM_W      = 8;
    localparam int PHASE_W    = 16;
    localparam int AMP_W      = 15;
    localparam int SAMP_W     = 16;
    localparam int NS_W       = 7;
    localparam int BPS_W      = 4;
    localparam int MODE_W     = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int TDATA_W    = 2 * SAMP_W;

    // Limits
    localparam int MAX_SAMPLES = 64;
    localparam int BPS_MAX     = SYM_W;

    // Sine table geometry: the full table is folded into one quarter wave
    localparam int SINE_TABLE_DEPTH = 1024;
    localparam int SINE_IDX_W       = $clog2(SINE_TABLE_DEPTH);
    localparam int QTR_DEPTH        = SINE_TABLE_DEPTH / 4;
    localparam int QTR_W            = SINE_IDX_W - 2;
    localparam int QTR_STEP         = 16384 / QTR_DEPTH;

    localparam logic [PHASE_W-1:0] QUARTER_TURN = 16'h4000;
    localparam logic [AMP_W-1:0]   MAG_FULL     = '1;
    localparam logic [30:0]        ROUND_HALF   = 31'd16384;

    // Symbol queue between front and back end
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // Output mode codes
    localparam logic [MODE_W-1:0] MODE_RESTART = 2'd0;
    localparam logic [MODE_W-1:0] MODE_CONT    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CPLX    = 2'd2;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BPS    = 3'd0,
        CFG_OFFSET = 3'd1,
        CFG_AMP    = 3'd2,
        CFG_STEP   = 3'd3,
        CFG_NSAMP  = 3'd4,
        CFG_MODE   = 3'd5,
        CFG_WAVE   = 3'd6
    } cfg_idx_t;

    // Reset values of the configuration registers
    localparam logic [BPS_W-1:0]   RST_BPS    = 4'd1;
    localparam logic [PHASE_W-1:0] RST_OFFSET = 16'd0;
    localparam logic [AMP_W-1:0]   RST_AMP    = 15'd32767;
    localparam logic [PHASE_W-1:0] RST_STEP   = 16'd4096;
    localparam logic [NS_W-1:0]    RST_NSAMP  = 7'd16;
    localparam logic [MODE_W-1:0]  RST_MODE   = MODE_RESTART;
    localparam logic               RST_WAVE   = 1'b0;

    // Effective (clamped and decoded) configuration
    typedef struct packed {
        logic [BPS_W-1:0]   bps;
        logic [PHASE_W-1:0] offset;
        logic [AMP_W-1:0]   amp;
        logic [PHASE_W-1:0] step;
        logic [NS_W-1:0]    nsamp;
        logic               cplx;
        logic               cont;
        logic               cosine;
    } dsm_cfg_t;

    // One classified symbol waiting for the back end
    typedef struct packed {
        logic [PHASE_W-1:0] phase;
        logic               msg_start;
    } sym_entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_stat_t;

    typedef enum logic {
        BK_IDLE,
        BK_RUN
    } bk_state_t;

    // Folded sine lookup result
    typedef struct packed {
        logic             neg;
        logic [AMP_W-1:0] mag;
    } wave_pt_t;

    typedef logic [QTR_DEPTH-1:0][AMP_W-1:0] qsin_rom_t;

    // Odd polynomial coefficients, Q30
    localparam longint unsigned K_A1 = 64'd1686629713;
    localparam longint unsigned K_A3 = 64'd693598668;
    localparam longint unsigned K_A5 = 64'd85569306;
    localparam longint unsigned K_A7 = 64'd5026995;
    localparam longint unsigned K_A9 = 64'd172272;

    // sin(pi/2 * x / 16384) as a Q1.15 magnitude, capped at full scale
    function automatic logic [AMP_W-1:0] quarter_sine(input logic [14:0] x);
        longint unsigned z;
        longint unsigned z2;
        longint unsigned t;
        longint unsigned s;
        longint unsigned m;
        z  = 64'(x) << 16;
        z2 = (z * z) >> 30;
        t  = K_A9;
        t  = K_A7 - ((t * z2) >> 30);
        t  = K_A5 - ((t * z2) >> 30);
        t  = K_A3 - ((t * z2) >> 30);
        t  = K_A1 - ((t * z2) >> 30);
        s  = (t * z) >> 30;
        m  = (s + 64'd16384) >> 15;
        if (m > 64'd32767) begin
            return MAG_FULL;
        end
        return AMP_W'(m);
    endfunction

    // Fill the quarter-wave table at elaboration
    function automatic qsin_rom_t build_qsin();
        qsin_rom_t rom;
        for (int j = 0; j < QTR_DEPTH; j++) begin
            rom[j] = quarter_sine(15'(j * QTR_STEP));
        end
        return rom;
    endfunction

    localparam qsin_rom_t QSIN_ROM = build_qsin();

endpackage

// ===== src/dsm_cfg.sv =====
// Configuration registers of the DPSK symbol modulator, with clamping of out-of-range values.
module dsm_cfg (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [dsm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [dsm_pkg::CFG_DATA_W-1:0]  cfg_data,
    output dsm_pkg::dsm_cfg_t               cfg_eff
);

    logic [dsm_pkg::BPS_W-1:0]   bps_reg;
    logic [dsm_pkg::PHASE_W-1:0] offset_reg;
    logic [dsm_pkg::AMP_W-1:0]   amp_reg;
    logic [dsm_pkg::PHASE_W-1:0] step_reg;
    logic [dsm_pkg::NS_W-1:0]    nsamp_reg;
    logic [dsm_pkg::MODE_W-1:0]  mode_reg;
    logic                        wave_reg;

    assign cfg_ready = 1'b1;

    // Store a register on each write transfer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bps_reg    <= dsm_pkg::RST_BPS;
            offset_reg <= dsm_pkg::RST_OFFSET;
            amp_reg    <= dsm_pkg::RST_AMP;
            step_reg   <= dsm_pkg::RST_STEP;
            nsamp_reg  <= dsm_pkg::RST_NSAMP;
            mode_reg   <= dsm_pkg::RST_MODE;
            wave_reg   <= dsm_pkg::RST_WAVE;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                dsm_pkg::CFG_BPS:    bps_reg    <= cfg_data[dsm_pkg::BPS_W-1:0];
                dsm_pkg::CFG_OFFSET: offset_reg <= cfg_data[dsm_pkg::PHASE_W-1:0];
                dsm_pkg::CFG_AMP:    amp_reg    <= cfg_data[dsm_pkg::AMP_W-1:0];
                dsm_pkg::CFG_STEP:   step_reg   <= cfg_data[dsm_pkg::PHASE_W-1:0];
                dsm_pkg::CFG_NSAMP:  nsamp_reg  <= cfg_data[dsm_pkg::NS_W-1:0];
                dsm_pkg::CFG_MODE:   mode_reg   <= cfg_data[dsm_pkg::MODE_W-1:0];
                dsm_pkg::CFG_WAVE:   wave_reg   <= cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // Clamp counts and decode the mode
    always_comb begin
        cfg_eff.offset = offset_reg;
        cfg_eff.amp    = amp_reg;
        cfg_eff.step   = step_reg;
        cfg_eff.cosine = wave_reg;
        cfg_eff.cont   = (mode_reg == dsm_pkg::MODE_CONT);
        cfg_eff.cplx   = (mode_reg >= dsm_pkg::MODE_CPLX);

        if (bps_reg == '0) begin
            cfg_eff.bps = dsm_pkg::BPS_W'(1);
        end else if (bps_reg > dsm_pkg::BPS_W'(dsm_pkg::BPS_MAX)) begin
            cfg_eff.bps = dsm_pkg::BPS_W'(dsm_pkg::BPS_MAX);
        end else begin
            cfg_eff.bps = bps_reg;
        end

        if (nsamp_reg == '0) begin
            cfg_eff.nsamp = dsm_pkg::NS_W'(1);
        end else if (nsamp_reg > dsm_pkg::NS_W'(dsm_pkg::MAX_SAMPLES)) begin
            cfg_eff.nsamp = dsm_pkg::NS_W'(dsm_pkg::MAX_SAMPLES);
        end else begin
            cfg_eff.nsamp = nsamp_reg;
        end
    end

endmodule

// ===== src/dsm_front.sv =====
// Front end: accepts symbols, undoes the Gray mapping and advances the differential phase.
module dsm_front (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  dsm_pkg::dsm_cfg_t           cfg_eff,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [dsm_pkg::SYM_W-1:0]   s_tdata,
    input  logic                        s_tuser,
    input  logic                        q_full,
    output logic                        q_push,
    output dsm_pkg::sym_entry_t         q_wdata
);

    logic [dsm_pkg::PHASE_W-1:0] phase_reg;
    logic [dsm_pkg::PHASE_W-1:0] phase_next;
    logic [dsm_pkg::SYM_W:0]     mask_w;
    logic [dsm_pkg::SYM_W-1:0]   sym_m;
    logic [dsm_pkg::SYM_W-1:0]   gray_i;
    logic [dsm_pkg::PHASE_W-1:0] gray_w;
    logic [4:0]                  shift_amt;
    logic [dsm_pkg::PHASE_W-1:0] phase_inc;

    assign s_tready = !q_full;
    assign q_push   = s_tvalid && s_tready;

    // Gray index: each bit is the XOR of all symbol bits at or above it
    always_comb begin
        mask_w = ((dsm_pkg::SYM_W + 1)'(1) << cfg_eff.bps) - (dsm_pkg::SYM_W + 1)'(1);
        sym_m  = s_tdata & mask_w[dsm_pkg::SYM_W-1:0];
        gray_i[dsm_pkg::SYM_W-1] = sym_m[dsm_pkg::SYM_W-1];
        for (int b = dsm_pkg::SYM_W - 2; b >= 0; b--) begin
            gray_i[b] = gray_i[b+1] ^ sym_m[b];
        end
        gray_w     = dsm_pkg::PHASE_W'(gray_i);
        shift_amt  = 5'(dsm_pkg::PHASE_W) - 5'(cfg_eff.bps);
        phase_inc  = gray_w << shift_amt;
        phase_next = phase_reg + phase_inc + cfg_eff.offset;
    end

    assign q_wdata.phase     = phase_next;
    assign q_wdata.msg_start = s_tuser;

    // Advance the running phase on each accepted symbol
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= '0;
        end else if (q_push) begin
            phase_reg <= phase_next;
        end
    end

endmodule

// ===== src/dsm_queue.sv =====
// Small FIFO of classified symbols between the front end and the sample back end.
module dsm_queue (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    push,
    input  dsm_pkg::sym_entry_t     wdata,
    input  logic                    pop,
    output dsm_pkg::sym_entry_t     rdata,
    output dsm_pkg::queue_stat_t    stat
);

    dsm_pkg::sym_entry_t           mem [dsm_pkg::QUEUE_DEPTH];
    logic [dsm_pkg::QUEUE_AW-1:0]  wr_ptr_reg;
    logic [dsm_pkg::QUEUE_AW-1:0]  rd_ptr_reg;
    logic [dsm_pkg::QUEUE_AW:0]    count_reg;

    assign stat.full  = (count_reg == (dsm_pkg::QUEUE_AW + 1)'(dsm_pkg::QUEUE_DEPTH));
    assign stat.empty = (count_reg == '0);
    assign rdata      = mem[rd_ptr_reg];

    // Write the entry store
    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= wdata;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + dsm_pkg::QUEUE_AW'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + dsm_pkg::QUEUE_AW'(1);
            end
            if (push && !pop) begin
                count_reg <= count_reg + (dsm_pkg::QUEUE_AW + 1)'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - (dsm_pkg::QUEUE_AW + 1)'(1);
            end
        end
    end

endmodule

// ===== src/dsm_back.sv =====
// Back end: sequences the samples of each symbol through a sine lookup and scaling pipeline.
module dsm_back (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  dsm_pkg::dsm_cfg_t               cfg_eff,
    input  dsm_pkg::sym_entry_t             q_rdata,
    input  logic                            q_empty,
    output logic                            q_pop,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [dsm_pkg::TDATA_W-1:0]     m_tdata,
    output logic                            m_tlast,
    output logic                            busy
);

    // Fold the angle into the quarter-wave table
    function automatic dsm_pkg::wave_pt_t sine_lookup(input logic [dsm_pkg::PHASE_W-1:0] ang);
        logic [dsm_pkg::SINE_IDX_W-1:0] idx;
        logic [1:0]                     quad;
        logic [dsm_pkg::QTR_W:0]        fine;
        logic [dsm_pkg::QTR_W:0]        xu;
        dsm_pkg::wave_pt_t              pt;
        idx  = ang[dsm_pkg::PHASE_W-1 -: dsm_pkg::SINE_IDX_W];
        quad = idx[dsm_pkg::SINE_IDX_W-1 -: 2];
        fine = (dsm_pkg::QTR_W + 1)'(idx[dsm_pkg::QTR_W-1:0]);
        xu   = quad[0] ? ((dsm_pkg::QTR_W + 1)'(dsm_pkg::QTR_DEPTH) - fine) : fine;
        pt.neg = quad[1];
        pt.mag = xu[dsm_pkg::QTR_W] ? dsm_pkg::MAG_FULL
                                    : dsm_pkg::QSIN_ROM[xu[dsm_pkg::QTR_W-1:0]];
        return pt;
    endfunction

    dsm_pkg::bk_state_t state_reg;
    dsm_pkg::bk_state_t state_next;

    logic                        adv;
    logic                        issue;
    logic                        last_issue;

    logic [dsm_pkg::PHASE_W-1:0] phase_reg;
    logic [dsm_pkg::NS_W-1:0]    cnt_reg;
    logic [dsm_pkg::PHASE_W-1:0] lacc_reg;
    logic [dsm_pkg::PHASE_W-1:0] tacc_reg;

    logic [dsm_pkg::PHASE_W-1:0] diff;
    logic [dsm_pkg::PHASE_W-1:0] ang_a_next;
    logic                        neg1_next;

    // Stage 1: angles
    logic                        v1_reg;
    logic [dsm_pkg::PHASE_W-1:0] ang_a1_reg;
    logic [dsm_pkg::PHASE_W-1:0] ang_b1_reg;
    logic                        neg1_reg;
    logic                        cplx1_reg;
    logic                        last1_reg;

    // Stage 2: table magnitudes
    dsm_pkg::wave_pt_t           pt_a;
    dsm_pkg::wave_pt_t           pt_b;
    logic                        v2_reg;
    logic [dsm_pkg::AMP_W-1:0]   mag_a2_reg;
    logic [dsm_pkg::AMP_W-1:0]   mag_b2_reg;
    logic                        neg_a2_reg;
    logic                        neg_b2_reg;
    logic                        cplx2_reg;
    logic                        last2_reg;

    // Stage 3: scaled magnitudes
    logic [30:0]                 prod;
    logic                        v3_reg;
    logic [dsm_pkg::AMP_W-1:0]   mag_a3_reg;
    logic [dsm_pkg::AMP_W-1:0]   mag_b3_reg;
    logic                        neg_a3_reg;
    logic                        neg_b3_reg;
    logic                        cplx3_reg;
    logic                        last3_reg;

    // Output register
    logic                        out_valid_reg;
    logic [dsm_pkg::SAMP_W-1:0]  sample_reg;
    logic [dsm_pkg::SAMP_W-1:0]  quad_reg;
    logic                        last_reg;
    logic [dsm_pkg::SAMP_W-1:0]  sample_next;
    logic [dsm_pkg::SAMP_W-1:0]  quad_next;

    // Whole pipeline moves when the output register can take a new sample
    assign adv        = !out_valid_reg || m_tready;
    assign last_issue = cfg_eff.cplx || (cnt_reg == (cfg_eff.nsamp - dsm_pkg::NS_W'(1)));

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            dsm_pkg::BK_IDLE: begin
                if (!q_empty) begin
                    state_next = dsm_pkg::BK_RUN;
                end
            end
            dsm_pkg::BK_RUN: begin
                if (issue && last_issue) begin
                    state_next = dsm_pkg::BK_IDLE;
                end
            end
            default: state_next = dsm_pkg::BK_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb begin
        q_pop = 1'b0;
        issue = 1'b0;
        case (state_reg)
            dsm_pkg::BK_IDLE: q_pop = !q_empty;
            dsm_pkg::BK_RUN:  issue = adv;
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= dsm_pkg::BK_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Load a symbol and step the sample counters
    always_ff @(posedge aclk) begin
        if (q_pop) begin
            phase_reg <= q_rdata.phase;
            cnt_reg   <= '0;
            lacc_reg  <= '0;
        end else if (issue) begin
            cnt_reg  <= cnt_reg + dsm_pkg::NS_W'(1);
            lacc_reg <= lacc_reg + cfg_eff.step;
        end
    end

    // Continuous carrier phase
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tacc_reg <= '0;
        end else if (q_pop && q_rdata.msg_start) begin
            tacc_reg <= '0;
        end else if (issue && cfg_eff.cont) begin
            tacc_reg <= tacc_reg + cfg_eff.step;
        end
    end

    // Sample angle for the current mode
    always_comb begin
        diff       = (cfg_eff.cont ? tacc_reg : lacc_reg) - phase_reg;
        ang_a_next = diff;
        neg1_next  = 1'b0;
        if (cfg_eff.cplx) begin
            ang_a_next = phase_reg + dsm_pkg::QUARTER_TURN;
        end else if (cfg_eff.cont) begin
            neg1_next = cfg_eff.cosine;
        end else if (cfg_eff.cosine) begin
            ang_a_next = diff + dsm_pkg::QUARTER_TURN;
        end
    end

    assign pt_a = sine_lookup(ang_a1_reg);
    assign pt_b = sine_lookup(ang_b1_reg);
    assign prod = 31'(cfg_eff.amp) * 31'(mag_a2_reg) + dsm_pkg::ROUND_HALF;

    // Apply signs at the output
    always_comb begin
        sample_next = neg_a3_reg ? (dsm_pkg::SAMP_W'(0) - dsm_pkg::SAMP_W'(mag_a3_reg))
                                 : dsm_pkg::SAMP_W'(mag_a3_reg);
        quad_next   = '0;
        if (cplx3_reg) begin
            quad_next = neg_b3_reg ? (dsm_pkg::SAMP_W'(0) - dsm_pkg::SAMP_W'(mag_b3_reg))
                                   : dsm_pkg::SAMP_W'(mag_b3_reg);
        end
    end

    // Stage valids
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            v1_reg        <= issue;
            v2_reg        <= v1_reg;
            v3_reg        <= v2_reg;
            out_valid_reg <= v3_reg;
        end
    end

    // Stage payloads
    always_ff @(posedge aclk) begin
        if (adv) begin
            ang_a1_reg <= ang_a_next;
            ang_b1_reg <= phase_reg;
            neg1_reg   <= neg1_next;
            cplx1_reg  <= cfg_eff.cplx;
            last1_reg  <= last_issue;

            mag_a2_reg <= pt_a.mag;
            mag_b2_reg <= pt_b.mag;
            neg_a2_reg <= pt_a.neg ^ neg1_reg;
            neg_b2_reg <= pt_b.neg;
            cplx2_reg  <= cplx1_reg;
            last2_reg  <= last1_reg;

            mag_a3_reg <= cplx2_reg ? mag_a2_reg : prod[29:15];
            mag_b3_reg <= mag_b2_reg;
            neg_a3_reg <= neg_a2_reg;
            neg_b3_reg <= neg_b2_reg;
            cplx3_reg  <= cplx2_reg;
            last3_reg  <= last2_reg;

            sample_reg <= sample_next;
            quad_reg   <= quad_next;
            last_reg   <= last3_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {quad_reg, sample_reg};
    assign m_tlast  = last_reg;
    assign busy     = (state_reg == dsm_pkg::BK_RUN) || v1_reg || v2_reg || v3_reg
                      || out_valid_reg;

endmodule

// ===== src/dpsk_symbol_modulator_top.sv =====
// Top level of the differential M-PSK symbol modulator with Gray mapping.
//
// Input stream: s_tdata[7:0] carries one M-ary symbol, s_tuser restarts the
// continuous carrier time at zero before that symbol. Each accepted symbol
// adds its Gray index times 2pi/M plus the phase offset to a 16-bit running
// phase. Output stream: m_tdata[15:0] is the sample (or cos in complex mode),
// m_tdata[31:16] the sin of complex mode (zero otherwise), m_tlast marks the
// final sample of a symbol. The config channel writes one register per transfer.
// Passband modes give samples_per_symbol samples per symbol, complex mode one.
// Throughput: the back-end sequencer issues one sample per cycle while the output is
// not stalled, and loads each symbol from the queue in its idle state before the
// samples of that symbol, whose number is capped at 64 in the passband modes.
// With the back end idle, a symbol's first sample passes the queue, the load state, stages 1-3 and the output register.
// A two-entry queue lets the front end keep accepting symbols while the back end
// works; s_tready drops only when that queue is full. When m_tready is low the
// whole sample pipeline holds, and the output register keeps its sample.
// Reset clears the running phase, the carrier time, the queue and the
// pipeline, and loads the default configuration.
module dpsk_symbol_modulator_top (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [dsm_pkg::SYM_W-1:0]       s_tdata,   // [7:0] symbol
    input  logic                            s_tuser,   // [0] message_start
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [dsm_pkg::TDATA_W-1:0]     m_tdata,   // [15:0] sample_out, [31:16] quadrature_out
    output logic                            m_tlast,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [dsm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [dsm_pkg::CFG_DATA_W-1:0]  cfg_data
);

    dsm_pkg::dsm_cfg_t     cfg_eff;
    dsm_pkg::sym_entry_t   q_wdata;
    dsm_pkg::sym_entry_t   q_rdata;
    dsm_pkg::queue_stat_t  q_stat;
    logic                  q_push;
    logic                  q_pop;
    logic                  bk_busy;

    dsm_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg_eff   (cfg_eff)
    );

    dsm_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_eff  (cfg_eff),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_full   (q_stat.full),
        .q_push   (q_push),
        .q_wdata  (q_wdata)
    );

    dsm_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .wdata   (q_wdata),
        .pop     (q_pop),
        .rdata   (q_rdata),
        .stat    (q_stat)
    );

    dsm_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_eff  (cfg_eff),
        .q_rdata  (q_rdata),
        .q_empty  (q_stat.empty),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .busy     (bk_busy)
    );

    // Reset empties the output register
    a_reset_clears_out: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

    // Queue status never claims full and empty together
    a_queue_status: assert property (@(posedge aclk) disable iff (!aresetn)
        !(q_stat.full && q_stat.empty))
        else $error("queue full and empty at once");

    // Back end dequeues only real entries
    a_pop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> !q_stat.empty)
        else $error("dequeue from empty queue");

    // After a non-final sample transfer the symbol is still in progress
    a_symbol_continues: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !m_tlast |=> bk_busy)
        else $error("symbol ended without a last sample");

endmodule

// ===== tb/sv/tb.sv =====
// Self-checking testbench for dpsk_symbol_modulator_top: a directed table, then random symbol traffic.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD     = 20;
    localparam int RESET_CYCLES   = 8;
    localparam int RANDOM_ITEMS   = 250;
    localparam int DRAIN_CYCLES   = 20;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int PRINT_CAP      = 100;
    localparam int RX_STYLE_SPAN  = 256;

    // Behavioral constants of the modulator as seen from its pins
    localparam int unsigned WAVE_TABLE_DEPTH = 1024;
    localparam int unsigned SAMPLE_CAP       = 64;
    localparam int unsigned FULL_SCALE       = 32768;

    // Odd polynomial for the quarter sine, Q30
    localparam longint unsigned POLY_C1 = 64'd1686629713;
    localparam longint unsigned POLY_C3 = 64'd693598668;
    localparam longint unsigned POLY_C5 = 64'd85569306;
    localparam longint unsigned POLY_C7 = 64'd5026995;
    localparam longint unsigned POLY_C9 = 64'd172272;

    // Codes not covered by the package
    localparam logic [dsm_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;
    localparam logic [dsm_pkg::MODE_W-1:0]    MODE_SPARE = 2'd3;

    typedef struct packed {
        logic [dsm_pkg::SAMP_W-1:0] samp;
        logic [dsm_pkg::SAMP_W-1:0] quad;
        logic                       last;
    } mod_out_t;

    typedef enum logic [1:0] {
        ROW_CFG,
        ROW_SYM,
        ROW_TYPED
    } row_kind_t;

    typedef struct packed {
        row_kind_t                        kind;
        logic [dsm_pkg::CFG_IDX_W-1:0]    idx;
        logic [dsm_pkg::CFG_DATA_W-1:0]   data;
        logic [dsm_pkg::SYM_W-1:0]        sym;
        logic                             msg;
        logic [dsm_pkg::SAMP_W-1:0]       want_samp;
        logic [dsm_pkg::SAMP_W-1:0]       want_quad;
    } dir_row_t;

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_COIN,
        RX_CADENCE,
        RX_HOLDOFF
    } rx_style_t;

    // Directed stimulus; typed rows carry their single expected result
    localparam int DIR_ROWS = 43;
    localparam dir_row_t DIR_TABLE [0:DIR_ROWS-1] = '{
        '{ROW_CFG,   dsm_pkg::CFG_MODE, 16'(dsm_pkg::MODE_CPLX), 8'h00, 1'b0, 16'd0, 16'd0},
        '{ROW_TYPED, dsm_pkg::CFG_BPS, 16'd0, 8'h00, 1'b0, 16'sd32767,  16'd0},
        '{ROW_TYPED, dsm_pkg::CFG_BPS, 16'd0, 8'h01, 1'b0, -16'sd32767, 16'd0},
        '{ROW_TYPED, dsm_pkg::CFG_BPS, 16'd0, 8'h01, 1'b0, 16'sd32767,  16'd0},
        '{ROW_CFG,   dsm_pkg::CFG_BPS, 16'd2, 8'h00, 1'b0, 16'd0,       16'd0},
        '{ROW_TYPED, dsm_pkg::CFG_BPS, 16'd0, 8'h01, 1'b0, 16'd0,       16'sd32767},
        '{ROW_TYPED, dsm_pkg::CFG_BPS, 16'd0, 8'h03, 1'b0, 16'd0,       -16'sd32767},
        '{ROW_CFG,   dsm_pkg::CFG_BPS, 16'd0, 8'h00, 1'b0, 16'd0,       16'd0},
        '{ROW_SYM,   dsm_pkg::CFG_BPS, 16'd0, 8'hFF, 1'b0, 16'd0,       16'd0},
        '{ROW_CFG,   dsm_pkg::CFG_BPS, 16'd15, 8'h00, 1'b0, 16'd0,      16'd0},
        '{ROW_SYM,   dsm_pkg::CFG_BPS, 16'd0, 8'hFF, 1'b0, 16'd0,       16'd0},
        '{ROW_SYM,   dsm_pkg::CFG_BPS, 16'd0, 8'h80, 1'b0, 16'd0,       16'd0},
        '{ROW_CFG,   dsm_pkg::CFG_MODE, 16'(MODE_SPARE), 8'h00, 1'b0, 16'd0, 16'd0},
        '{ROW_SYM,   dsm_pkg::CFG_BPS, 16'd0, 8'h55, 1'b1, 16'd0,       16'd0},
        '{ROW_CFG,   dsm_pkg::CFG_OFFSET, 16'hFFFF, 8'h00, 1'b0, 16'd0, 16'd0},
        '{ROW_SYM,   dsm_pkg::CFG_BPS, 16'd0, 8'h00, 1'b0, 16'd0,       16'd0},
        '{ROW_CFG,   CFG_UNUSED, 16'hFFFF, 8'h00, 1'b0, 16'd0,          16'd0},
        '{ROW_SYM,   dsm_pkg::CFG_BPS, 16'd0, 8'hAA, 1'b0, 16'd0,       16'd0},
        '{ROW_CFG,   dsm_pkg::CFG_MODE, 16'(dsm_pkg::MODE_RESTART), 8'h00, 1'b0, 16'd0, 16'd0},
        '{ROW_CFG,   dsm_pkg::CFG_OFFSET, 16'd0, 8'h00, 1'b0, 16'd0,    16'd0},
        '{ROW_CFG,   dsm_pkg::CFG_BPS, 16'd1, 8'h00, 1'b0, 16'd0,       16'd0},
        '{ROW_SYM,   dsm_pkg::CFG_BPS, 16'd0, 8'h00, 1'b0, 16'd0,       16'd0},
        '{ROW_SYM,   dsm_pkg::CFG_BPS, 16'd0, 8'h01, 1'b0, 16'd0,       16'd0},
        '{ROW_CFG,   dsm_pkg::CFG_NSAMP, 16'd0, 8'h00, 1'b0, 16'd0,     16'd0},
        '{ROW_CFG,   dsm_pkg::CFG_AMP, 16'd0, 8'h00, 1'b0, 16'd0,       16'd0},
        '{ROW_TYPED, dsm_pkg::CFG_BPS, 16'd0, 8'h01, 1'b0, 16'd0,       16'd0},
        '{ROW_CFG,   dsm_pkg::CFG_AMP, 16'd32767, 8'h00, 1'b0, 16'd0,   16'd0},
        '{ROW_CFG,   dsm_pkg::CFG_NSAMP, 16'd127, 8'h00, 1'b0, 16'd0,   16'd0},
        '{ROW_CFG,   dsm_pkg::CFG_STEP, 16'hFFFF, 8'h00, 1'b0, 16'd0,   16'd0},
        '{ROW_CFG,   dsm_pkg::CFG_WAVE, 16'd1, 8'h00, 1'b0, 16'd0,      16'd0},
        '{ROW_SYM,   dsm_pkg::CFG_BPS, 16'd0, 8'h00, 1'b0, 16'd0,       16'd0},
        '{ROW_CFG,   dsm_pkg::CFG_STEP, 16'd0, 8'h00, 1'b0, 16'd0,      16'd0},
        '{ROW_SYM,   dsm_pkg::CFG_BPS, 16'd0, 8'h01, 1'b1, 16'd0,       16'd0},
        '{ROW_CFG,   dsm_pkg::CFG_MODE, 16'(dsm_pkg::MODE_CONT), 8'h00, 1'b0, 16'd0, 16'd0},
        '{ROW_CFG,   dsm_pkg::CFG_NSAMP, 16'd64, 8'h00, 1'b0, 16'd0,    16'd0},
        '{ROW_CFG,   dsm_pkg::CFG_STEP, 16'h1234, 8'h00, 1'b0, 16'd0,   16'd0},
        '{ROW_SYM,   dsm_pkg::CFG_BPS, 16'd0, 8'h01, 1'b1, 16'd0,       16'd0},
        '{ROW_SYM,   dsm_pkg::CFG_BPS, 16'd0, 8'h00, 1'b0, 16'd0,       16'd0},
        '{ROW_CFG,   dsm_pkg::CFG_WAVE, 16'd0, 8'h00, 1'b0, 16'd0,      16'd0},
        '{ROW_SYM,   dsm_pkg::CFG_BPS, 16'd0, 8'h01, 1'b0, 16'd0,       16'd0},
        '{ROW_SYM,   dsm_pkg::CFG_BPS, 16'd0, 8'h00, 1'b1, 16'd0,       16'd0},
        '{ROW_CFG,   dsm_pkg::CFG_NSAMP, 16'd1, 8'h00, 1'b0, 16'd0,     16'd0},
        '{ROW_SYM,   dsm_pkg::CFG_BPS, 16'd0, 8'hFF, 1'b0, 16'd0,       16'd0}
    };

    logic                            aclk      = 1'b0;
    logic                            aresetn   = 1'b0;
    logic                            s_tvalid  = 1'b0;
    logic                            s_tready;
    logic [dsm_pkg::SYM_W-1:0]       s_tdata   = '0;
    logic                            s_tuser   = 1'b0;
    logic                            m_tvalid;
    logic                            m_tready  = 1'b0;
    logic [dsm_pkg::TDATA_W-1:0]     m_tdata;
    logic                            m_tlast;
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [dsm_pkg::CFG_IDX_W-1:0]   cfg_index = '0;
    logic [dsm_pkg::CFG_DATA_W-1:0]  cfg_data  = '0;

    // Shadow configuration and modulator state
    logic [dsm_pkg::BPS_W-1:0]   bps_cfg      = 4'd1;
    logic [dsm_pkg::PHASE_W-1:0] offset_cfg   = 16'd0;
    logic [dsm_pkg::AMP_W-1:0]   amp_cfg      = 15'd32767;
    logic [dsm_pkg::PHASE_W-1:0] step_cfg     = 16'd4096;
    logic [dsm_pkg::NS_W-1:0]    nsamp_cfg    = 7'd16;
    logic [dsm_pkg::MODE_W-1:0]  mode_cfg     = dsm_pkg::MODE_RESTART;
    logic                        wave_cfg     = 1'b0;
    logic [dsm_pkg::PHASE_W-1:0] sym_phase    = '0;
    logic [dsm_pkg::PHASE_W-1:0] carrier_time = '0;

    mod_out_t pending_samples[$];
    mod_out_t symbol_samples[$];
    mod_out_t front_want;

    int        err_count    = 0;
    int        burst_left   = 0;
    int        quiet_cycles = 0;
    int        rx_cycle     = 0;
    int        rx_hold      = 0;
    rx_style_t rx_style     = RX_OPEN;

    dpsk_symbol_modulator_top u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),    // [7:0] symbol
        .s_tuser   (s_tuser),    // [0] message_start
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),    // [15:0] sample_out, [31:16] quadrature_out
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // sin(pi/2 * x / 16384) as a Q1.15 magnitude, capped at full scale
    function automatic int unsigned poly_sine(input int unsigned x);
        longint unsigned z;
        longint unsigned z2;
        longint unsigned t;
        longint unsigned s;
        longint unsigned m;
        z  = 64'(x) << 16;
        z2 = (z * z) >> 30;
        t  = POLY_C9;
        t  = POLY_C7 - ((t * z2) >> 30);
        t  = POLY_C5 - ((t * z2) >> 30);
        t  = POLY_C3 - ((t * z2) >> 30);
        t  = POLY_C1 - ((t * z2) >> 30);
        s  = (t * z) >> 30;
        m  = (s + 64'd16384) >> 15;
        return (m > 64'd32767) ? 32'd32767 : 32'(m);
    endfunction

    // Scaled table sine, or cosine when use_cos is set
    function automatic int carrier_wave(input logic [dsm_pkg::PHASE_W-1:0] angle,
                                        input bit use_cos, input int unsigned amp);
        logic [dsm_pkg::PHASE_W-1:0] a;
        int unsigned idx;
        int unsigned q;
        int unsigned quadrant;
        int unsigned r;
        int unsigned x;
        longint unsigned mag;
        a        = use_cos ? angle + 16'h4000 : angle;
        idx      = (32'(a) * WAVE_TABLE_DEPTH) >> 16;
        q        = ((idx << 16) / WAVE_TABLE_DEPTH) & 32'hFFFF;
        quadrant = (q >> 14) & 32'd3;
        r        = q & 32'h3FFF;
        x        = quadrant[0] ? 32'd16384 - r : r;
        mag      = (64'(amp) * poly_sine(x) + 64'd16384) >> 15;
        return (quadrant >= 2) ? -int'(mag) : int'(mag);
    endfunction

    // Advance the running phase for one symbol and list the samples it produces
    task automatic modulate_symbol(input logic [dsm_pkg::SYM_W-1:0] sym, input logic msg);
        int unsigned bps;
        int unsigned nsamp;
        int unsigned mask;
        int unsigned gidx;
        int unsigned k;
        logic [dsm_pkg::PHASE_W-1:0] ang;
        int v;
        symbol_samples.delete();
        bps   = (bps_cfg < 1) ? 1 : ((bps_cfg > 8) ? 8 : bps_cfg);
        nsamp = (nsamp_cfg < 1) ? 1 : nsamp_cfg;
        if (nsamp > SAMPLE_CAP) begin
            nsamp = SAMPLE_CAP;
        end
        mask = (1 << bps) - 1;
        if (msg) begin
            carrier_time = '0;
        end
        // Undo the reflected Gray code to get the phase index
        gidx = sym & mask;
        gidx ^= gidx >> 1;
        gidx ^= gidx >> 2;
        gidx ^= gidx >> 4;
        gidx &= mask;
        sym_phase = sym_phase + 16'(gidx << (16 - bps)) + offset_cfg;
        if (mode_cfg >= dsm_pkg::MODE_CPLX) begin
            symbol_samples.push_back('{samp: 16'(carrier_wave(sym_phase, 1'b1, FULL_SCALE)),
                                       quad: 16'(carrier_wave(sym_phase, 1'b0, FULL_SCALE)),
                                       last: 1'b1});
        end else begin
            for (k = 0; k < nsamp; k++) begin
                if (mode_cfg == dsm_pkg::MODE_RESTART) begin
                    ang = 16'(step_cfg * k - sym_phase);
                    v   = carrier_wave(ang, wave_cfg, amp_cfg);
                end else begin
                    // Mixer identity: the cosine carrier comes out as a negated sine
                    ang = carrier_time - sym_phase;
                    v   = carrier_wave(ang, 1'b0, amp_cfg);
                    if (wave_cfg) begin
                        v = -v;
                    end
                    carrier_time = carrier_time + step_cfg;
                end
                symbol_samples.push_back('{samp: 16'(v), quad: 16'd0, last: (k + 1 == nsamp)});
            end
        end
    endtask

    task automatic shadow_write(input logic [dsm_pkg::CFG_IDX_W-1:0] idx,
                                input logic [dsm_pkg::CFG_DATA_W-1:0] data);
        case (idx)
            dsm_pkg::CFG_BPS:    bps_cfg    = data[dsm_pkg::BPS_W-1:0];
            dsm_pkg::CFG_OFFSET: offset_cfg = data[dsm_pkg::PHASE_W-1:0];
            dsm_pkg::CFG_AMP:    amp_cfg    = data[dsm_pkg::AMP_W-1:0];
            dsm_pkg::CFG_STEP:   step_cfg   = data[dsm_pkg::PHASE_W-1:0];
            dsm_pkg::CFG_NSAMP:  nsamp_cfg  = data[dsm_pkg::NS_W-1:0];
            dsm_pkg::CFG_MODE:   mode_cfg   = data[dsm_pkg::MODE_W-1:0];
            dsm_pkg::CFG_WAVE:   wave_cfg   = data[0];
            default: ;
        endcase
    endtask

    task automatic report_error(input string what);
        err_count++;
        if (err_count <= PRINT_CAP) begin
            $display("%0t ns: mismatch: %s", $realtime, what);
        end
    endtask

    // Stop sending and hold until every expected sample has come back
    task automatic wait_drained();
        if (s_tvalid) begin
            s_tvalid <= 1'b0;
        end
        do @(posedge aclk); while (pending_samples.size() != 0);
    endtask

    // Write one register; valid stays high so back-to-back writes stream
    task automatic write_reg(input logic [dsm_pkg::CFG_IDX_W-1:0] idx,
                             input logic [dsm_pkg::CFG_DATA_W-1:0] data);
        if (!cfg_valid) begin
            wait_drained();
        end
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        shadow_write(idx, data);
    endtask

    task automatic close_cfg();
        if (cfg_valid) begin
            cfg_valid <= 1'b0;
        end
    endtask

    // Send one symbol in bursts with random gaps, then queue its samples
    task automatic send_symbol(input logic [dsm_pkg::SYM_W-1:0] sym, input logic msg,
                               input bit typed,
                               input logic [dsm_pkg::SAMP_W-1:0] want_samp,
                               input logic [dsm_pkg::SAMP_W-1:0] want_quad);
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 8);
            if (s_tvalid) begin
                s_tvalid <= 1'b0;
            end
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= sym;
        s_tuser  <= msg;
        do @(posedge aclk); while (!s_tready);
        modulate_symbol(sym, msg);
        if (typed) begin
            pending_samples.push_back('{samp: want_samp, quad: want_quad, last: 1'b1});
        end else begin
            foreach (symbol_samples[j]) begin
                pending_samples.push_back(symbol_samples[j]);
            end
        end
    endtask

    function automatic logic [dsm_pkg::CFG_DATA_W-1:0] random_setting(
        input logic [dsm_pkg::CFG_IDX_W-1:0] idx);
        logic [dsm_pkg::CFG_DATA_W-1:0] v;
        v = '0;
        case (idx)
            dsm_pkg::CFG_BPS: v = 16'($urandom_range(0, 15));
            dsm_pkg::CFG_OFFSET, dsm_pkg::CFG_STEP: begin
                case ($urandom_range(0, 5))
                    0:       v = 16'h0000;
                    1:       v = 16'hFFFF;
                    default: v = 16'($urandom);
                endcase
            end
            dsm_pkg::CFG_AMP: begin
                case ($urandom_range(0, 4))
                    0:       v = 16'd0;
                    1:       v = 16'd32767;
                    default: v = 16'($urandom_range(0, 32767));
                endcase
            end
            dsm_pkg::CFG_NSAMP: begin
                // Mostly short symbols; the longest and the clamped ones now and then
                case ($urandom_range(0, 9))
                    0:       v = 16'd0;
                    1:       v = 16'd64;
                    2:       v = 16'd127;
                    default: v = 16'($urandom_range(1, 16));
                endcase
            end
            dsm_pkg::CFG_MODE: v = 16'($urandom_range(0, 3));
            dsm_pkg::CFG_WAVE: v = 16'($urandom_range(0, 1));
            default: ;
        endcase
        return v;
    endfunction

    // Receiver back-pressure: switch at random between open, coin-flip, cadence and long holds
    always @(posedge aclk) begin
        rx_cycle++;
        if (rx_cycle % RX_STYLE_SPAN == 0) begin
            rx_style = rx_style_t'($urandom_range(0, 3));
        end
        case (rx_style)
            RX_OPEN:    m_tready <= 1'b1;
            RX_COIN:    m_tready <= 1'($urandom_range(0, 1));
            RX_CADENCE: m_tready <= (rx_cycle % 4) != 3;
            default: begin
                if (rx_hold > 0) begin
                    rx_hold--;
                    m_tready <= 1'b0;
                end else if ($urandom_range(0, 15) == 0) begin
                    rx_hold = $urandom_range(1, 12);
                    m_tready <= 1'b0;
                end else begin
                    m_tready <= 1'b1;
                end
            end
        endcase
    end

    // Check each sample transfer against the oldest expectation
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_samples.size() == 0) begin
                report_error($sformatf("unexpected sample %0d quad %0d last %0b",
                                       $signed(m_tdata[15:0]), $signed(m_tdata[31:16]), m_tlast));
            end else begin
                front_want = pending_samples.pop_front();
                if (m_tdata[15:0] !== front_want.samp || m_tdata[31:16] !== front_want.quad ||
                    m_tlast !== front_want.last) begin
                    report_error($sformatf("sample %0d/%0d quad %0d/%0d last %0b/%0b (got/exp)",
                                           $signed(m_tdata[15:0]), $signed(front_want.samp),
                                           $signed(m_tdata[31:16]), $signed(front_want.quad),
                                           m_tlast, front_want.last));
                end
            end
        end
    end

    // Watchdog: end the run when the block has taken no symbol or register for too long
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (cfg_valid && cfg_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    initial begin
        int  row;
        int  sent;
        int  plen;
        int  phase_no;
        int  k;
        int  r;
        bit  drained_once;
        sent         = 0;
        phase_no     = 0;
        drained_once = 1'b0;

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        // Walk the directed table
        for (row = 0; row < DIR_ROWS; row++) begin
            if (DIR_TABLE[row].kind == ROW_CFG) begin
                write_reg(DIR_TABLE[row].idx, DIR_TABLE[row].data);
            end else begin
                close_cfg();
                send_symbol(DIR_TABLE[row].sym, DIR_TABLE[row].msg,
                            DIR_TABLE[row].kind == ROW_TYPED,
                            DIR_TABLE[row].want_samp, DIR_TABLE[row].want_quad);
            end
        end

        // Random phases: a new setting, then a message of random symbols
        while (sent < RANDOM_ITEMS) begin
            for (r = dsm_pkg::CFG_BPS; r <= dsm_pkg::CFG_WAVE; r++) begin
                if (phase_no == 0 || $urandom_range(0, 2) != 0) begin
                    write_reg(dsm_pkg::CFG_IDX_W'(r),
                              random_setting(dsm_pkg::CFG_IDX_W'(r)));
                end
            end
            close_cfg();
            plen = $urandom_range(12, 40);
            for (k = 0; k < plen; k++) begin
                if (k == plen / 2 && (!drained_once || $urandom_range(0, 3) == 0)) begin
                    wait_drained();
                    drained_once = 1'b1;
                end
                send_symbol(8'($urandom_range(0, 255)), (k == 0) || ($urandom_range(0, 7) == 0),
                            1'b0, '0, '0);
                sent++;
            end
            phase_no++;
        end

        // Drain, then watch a little longer for stray samples
        close_cfg();
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (err_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
